// ----- rtl/cpm_pkg.sv -----
// ----------------------------------------------------------------------------
// cpm_pkg: shared types and constants for the C punctuator matcher
// Character codes, token codes, the punctuator tables and the match result.
// ----------------------------------------------------------------------------
package cpm_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned CodeW = 6;
	localparam int unsigned AdvW  = 3;

	localparam int unsigned NumPairs   = 19;
	localparam int unsigned NumSingles = 24;

	// Characters
	localparam logic [ByteW-1:0] CH_HASH    = 8'h23; // #
	localparam logic [ByteW-1:0] CH_PERCENT = 8'h25; // %
	localparam logic [ByteW-1:0] CH_COLON   = 8'h3a; // :
	localparam logic [ByteW-1:0] CH_DOT     = 8'h2e; // .
	localparam logic [ByteW-1:0] CH_LT      = 8'h3c; // <
	localparam logic [ByteW-1:0] CH_GT      = 8'h3e; // >
	localparam logic [ByteW-1:0] CH_EQ      = 8'h3d; // =
	localparam logic [ByteW-1:0] CH_MINUS   = 8'h2d; // -
	localparam logic [ByteW-1:0] CH_PLUS    = 8'h2b; // +
	localparam logic [ByteW-1:0] CH_AMP     = 8'h26; // &
	localparam logic [ByteW-1:0] CH_PIPE    = 8'h7c; // |
	localparam logic [ByteW-1:0] CH_CARET   = 8'h5e; // ^
	localparam logic [ByteW-1:0] CH_BANG    = 8'h21; // !
	localparam logic [ByteW-1:0] CH_STAR    = 8'h2a; // *
	localparam logic [ByteW-1:0] CH_SLASH   = 8'h2f; // /

	// Token codes
	localparam logic [CodeW-1:0] TOK_HASHHASH    = 6'd0;
	localparam logic [CodeW-1:0] TOK_ELLIPSIS    = 6'd1;
	localparam logic [CodeW-1:0] TOK_SHL_ASSIGN  = 6'd2;
	localparam logic [CodeW-1:0] TOK_SHR_ASSIGN  = 6'd3;
	localparam logic [CodeW-1:0] TOK_PAIR_BASE   = 6'd4;
	localparam logic [CodeW-1:0] TOK_HASH        = 6'd23;
	localparam logic [CodeW-1:0] TOK_SINGLE_BASE = 6'd24;
	localparam logic [CodeW-1:0] TOK_NONE        = 6'd0;

	// Advance lengths
	localparam logic [AdvW-1:0] ADV_NONE = 3'd0;
	localparam logic [AdvW-1:0] ADV_ONE  = 3'd1;
	localparam logic [AdvW-1:0] ADV_TWO  = 3'd2;
	localparam logic [AdvW-1:0] ADV_THREE = 3'd3;
	localparam logic [AdvW-1:0] ADV_FOUR = 3'd4;

	// Two-character punctuators in code order, first character in [15:8]
	localparam logic [2*ByteW-1:0] PAIR_TBL [NumPairs] = '{
		{CH_MINUS, CH_GT},   {CH_PLUS, CH_PLUS},  {CH_MINUS, CH_MINUS},
		{CH_LT, CH_LT},      {CH_GT, CH_GT},      {CH_LT, CH_EQ},
		{CH_GT, CH_EQ},      {CH_EQ, CH_EQ},      {CH_BANG, CH_EQ},
		{CH_AMP, CH_AMP},    {CH_PIPE, CH_PIPE},  {CH_STAR, CH_EQ},
		{CH_SLASH, CH_EQ},   {CH_PERCENT, CH_EQ}, {CH_PLUS, CH_EQ},
		{CH_MINUS, CH_EQ},   {CH_AMP, CH_EQ},     {CH_CARET, CH_EQ},
		{CH_PIPE, CH_EQ}
	};

	// Single-character punctuators in code order
	localparam logic [ByteW-1:0] SINGLE_TBL [NumSingles] = '{
		8'h5b, 8'h5d, 8'h28, 8'h29, 8'h7b, 8'h7d, CH_DOT, CH_AMP,
		CH_STAR, CH_PLUS, CH_MINUS, 8'h7e, CH_BANG, CH_SLASH, CH_PERCENT, CH_LT,
		CH_GT, CH_CARET, CH_PIPE, 8'h3f, CH_COLON, 8'h3b, CH_EQ, 8'h2c
	};

	typedef struct packed {
		logic             matched;
		logic [CodeW-1:0] code;
		logic [AdvW-1:0]  adv;
	} match_t;

endpackage

// ----- rtl/cpm_match.sv -----
// ----------------------------------------------------------------------------
// cpm_match: punctuator recognizer
// Combinational priority match of a four-byte window; longest form wins.
// ----------------------------------------------------------------------------
module cpm_match import cpm_pkg::*; (
	input  logic [ByteW-1:0] b0,
	input  logic [ByteW-1:0] b1,
	input  logic [ByteW-1:0] b2,
	input  logic [ByteW-1:0] b3,
	output match_t           res
);

	logic             pair_hit;
	logic [CodeW-1:0] pair_code;
	logic             single_hit;
	logic [CodeW-1:0] single_code;

	// Pair table entries are distinct, so at most one hits
	always_comb begin
		pair_hit  = 1'b0;
		pair_code = TOK_NONE;
		for (int i = 0; i < NumPairs; i++) begin
			if (b0 == PAIR_TBL[i][2*ByteW-1:ByteW] && b1 == PAIR_TBL[i][ByteW-1:0]) begin
				pair_hit  = 1'b1;
				pair_code = TOK_PAIR_BASE + CodeW'(i);
			end
		end
	end

	always_comb begin
		single_hit  = 1'b0;
		single_code = TOK_NONE;
		for (int i = 0; i < NumSingles; i++) begin
			if (b0 == SINGLE_TBL[i]) begin
				single_hit  = 1'b1;
				single_code = TOK_SINGLE_BASE + CodeW'(i);
			end
		end
	end

	always_comb begin
		res = '{matched: 1'b1, code: TOK_NONE, adv: ADV_NONE};
		if (b0 == CH_HASH && b1 == CH_HASH) begin
			res.code = TOK_HASHHASH;
			res.adv  = ADV_TWO;
		end else if (b0 == CH_PERCENT && b1 == CH_COLON && b2 == CH_PERCENT &&
				b3 == CH_COLON) begin
			res.code = TOK_HASHHASH;
			res.adv  = ADV_FOUR;
		end else if (b0 == CH_DOT && b1 == CH_DOT && b2 == CH_DOT) begin
			res.code = TOK_ELLIPSIS;
			res.adv  = ADV_THREE;
		end else if (b0 == CH_LT && b1 == CH_LT && b2 == CH_EQ) begin
			res.code = TOK_SHL_ASSIGN;
			res.adv  = ADV_THREE;
		end else if (b0 == CH_GT && b1 == CH_GT && b2 == CH_EQ) begin
			res.code = TOK_SHR_ASSIGN;
			res.adv  = ADV_THREE;
		end else if (pair_hit) begin
			res.code = pair_code;
			res.adv  = ADV_TWO;
		end else if (b0 == CH_HASH) begin
			res.code = TOK_HASH;
			res.adv  = ADV_ONE;
		end else if (b0 == CH_PERCENT && b1 == CH_COLON) begin
			res.code = TOK_HASH;
			res.adv  = ADV_TWO;
		end else if (single_hit) begin
			res.code = single_code;
			res.adv  = ADV_ONE;
		end else begin
			res.matched = 1'b0;
		end
	end

endmodule

// ----- rtl/c_punctuator_matcher_top.sv -----
// The match logic sits between the input register (stage 1) and the result register (stage 2).
// Throughput: one word per cycle while out_stall is low; the result register drives the output.
// Under output stall both stages hold, and the input stalls only when both are full.
// Reset (arst_n low, asynchronous) empties both stages; payload registers are not reset.
// ----------------------------------------------------------------------------
// c_punctuator_matcher_top: C punctuator matcher
// Recognizes the C punctuator at the start of a four-byte text window and
// returns its token code and the number of bytes to advance.
// ----------------------------------------------------------------------------
module c_punctuator_matcher_top import cpm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [ByteW-1:0] byte0,
	input  logic [ByteW-1:0] byte1,
	input  logic [ByteW-1:0] byte2,
	input  logic [ByteW-1:0] byte3,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             matched,
	output logic [CodeW-1:0] token_code,
	output logic [AdvW-1:0]  advance
);

	// Stage 1: registered input window
	logic             vld_s1;
	logic [ByteW-1:0] b0_s1, b1_s1, b2_s1, b3_s1;

	// Stage 2: registered result word
	logic   vld_s2;
	match_t res_s2;

	match_t res_comb;
	logic   adv_s2;   // stage 2 may load
	logic   adv_s1;   // stage 1 may load

	// Stage 2 loads when empty or when its word leaves this cycle;
	// stage 1 loads when empty or when it hands its word on.
	assign adv_s2   = !vld_s2 || !out_stall;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= in_valid;
		end
	end

	// Hold the window while stalled; load only on an accepted word
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			b0_s1 <= byte0;
			b1_s1 <= byte1;
			b2_s1 <= byte2;
			b3_s1 <= byte3;
		end
	end

	cpm_match u_match (
		.b0  (b0_s1),
		.b1  (b1_s1),
		.b2  (b2_s1),
		.b3  (b3_s1),
		.res (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	// Capture the result only when a window advances into stage 2
	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid  = vld_s2;
	assign matched    = res_s2.matched;
	assign token_code = res_s2.code;
	assign advance    = res_s2.adv;

endmodule

// ----- rtl/cpm_checker.sv -----
// ----------------------------------------------------------------------------
// cpm_checker: port-level checks for the C punctuator matcher
// Watches the output channel of the top level; attached by bind.
// ----------------------------------------------------------------------------
module cpm_checker import cpm_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_stall,
	input logic             matched,
	input logic [CodeW-1:0] token_code,
	input logic [AdvW-1:0]  advance
);

	// A stalled result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	// A miss carries zero code and zero advance
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !matched |-> token_code == TOK_NONE && advance == ADV_NONE)
		else $error("miss with nonzero code or advance");

	// A hit advances one to four bytes, and only the double hash digraph takes four
	a_hit_adv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && matched |-> advance != ADV_NONE &&
			(advance != ADV_FOUR || token_code == TOK_HASHHASH))
		else $error("bad advance for a hit");

	// Single-character tokens advance one byte
	a_single_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && matched && token_code >= TOK_SINGLE_BASE |-> advance == ADV_ONE)
		else $error("single-character token with wrong advance");

endmodule

bind c_punctuator_matcher_top cpm_checker u_cpm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.matched    (matched),
	.token_code (token_code),
	.advance    (advance)
);
